// ===== sv/erfx_pkg.sv =====
package erfx_pkg;

	localparam int unsigned EXP_TERMS = 12;
	localparam int unsigned EXP_LAT   = 3 + 2 * EXP_TERMS + 1;
	localparam int unsigned DIV_BITS  = 17;

	localparam logic [30:0] ONE_Q30    = 31'd1073741824;
	localparam logic [31:0] A_MAG_Q30  = 32'd2126008812;
	localparam logic [31:0] B_Q30      = 32'd2160084138;
	localparam logic [29:0] LN2_Q30    = 30'd744261118;
	// floor(2^40 / LN2_Q30): n estimate from t[36:24], low by at most one
	localparam logic [10:0] LN2_RECIP  = 11'd1477;

	// ceil(2^34 / k), exact floor division for dividends below 2^30
	function automatic logic [34:0] recip34(input logic [3:0] k);
		logic [34:0] m;
		case (k)
			4'd1:    m = 35'd17179869184;
			4'd2:    m = 35'd8589934592;
			4'd3:    m = 35'd5726623062;
			4'd4:    m = 35'd4294967296;
			4'd5:    m = 35'd3435973837;
			4'd6:    m = 35'd2863311531;
			4'd7:    m = 35'd2454267027;
			4'd8:    m = 35'd2147483648;
			4'd9:    m = 35'd1908874354;
			4'd10:   m = 35'd1717986919;
			4'd11:   m = 35'd1561806290;
			4'd12:   m = 35'd1431655766;
			default: m = 35'd0;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/erfx_exp.sv =====
module erfx_exp (
	input  logic        clk,
	input  logic        en,
	input  logic [36:0] t,
	output logic [30:0] e
);

	localparam int unsigned T = erfx_pkg::EXP_TERMS;

	logic        [23:0] nprod;
	logic        [37:0] nlnp;
	logic        [36:0] t_s1;
	logic        [7:0]  ne_s1;
	logic        [30:0] g0_s2;
	logic        [7:0]  ne_s2;

	logic        [29:0] g_sd    [0:T];
	logic        [7:0]  n_sd    [0:T];
	logic        [30:0] term_sd [0:T];
	logic signed [32:0] sum_sd  [0:T];

	logic        [29:0] p_sm    [1:T];
	logic        [29:0] g_sm    [1:T];
	logic        [7:0]  n_sm    [1:T];
	logic signed [32:0] sum_sm  [1:T];

	logic        [30:0] sum_clamp;

	assign nprod = 24'(t[36:24]) * 24'(erfx_pkg::LN2_RECIP);
	assign nlnp  = 38'(ne_s1) * 38'(erfx_pkg::LN2_Q30);

	// range reduction: t = n*ln2 + g
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t;
			ne_s1 <= nprod[23:16];
			g0_s2 <= 31'(38'(t_s1) - nlnp);
			ne_s2 <= ne_s1;
			if (g0_s2 >= 31'(erfx_pkg::LN2_Q30)) begin
				g_sd[0] <= 30'(g0_s2 - 31'(erfx_pkg::LN2_Q30));
				n_sd[0] <= ne_s2 + 8'd1;
			end else begin
				g_sd[0] <= g0_s2[29:0];
				n_sd[0] <= ne_s2;
			end
			term_sd[0] <= erfx_pkg::ONE_Q30;
			sum_sd[0]  <= $signed(33'(erfx_pkg::ONE_Q30));
		end
	end

	// Taylor terms: multiply stage, then divide-by-k stage
	for (genvar k = 1; k <= T; k++) begin : g_term
		logic [60:0] mul;
		logic [64:0] dq;
		logic [30:0] q;

		assign mul = 61'(term_sd[k-1]) * 61'(g_sd[k-1]);
		assign dq  = 65'(p_sm[k]) * 65'(erfx_pkg::recip34(4'(k)));
		assign q   = dq[64:34];

		always_ff @(posedge clk) begin
			if (en) begin
				p_sm[k]   <= mul[59:30];
				g_sm[k]   <= g_sd[k-1];
				n_sm[k]   <= n_sd[k-1];
				sum_sm[k] <= sum_sd[k-1];
				term_sd[k] <= q;
				g_sd[k]    <= g_sm[k];
				n_sd[k]    <= n_sm[k];
				if ((k % 2) == 1)
					sum_sd[k] <= sum_sm[k] - $signed({2'b00, q});
				else
					sum_sd[k] <= sum_sm[k] + $signed({2'b00, q});
			end
		end
	end

	always_comb begin
		if (sum_sd[T] < 0)
			sum_clamp = '0;
		else if (sum_sd[T] > $signed(33'(erfx_pkg::ONE_Q30)))
			sum_clamp = erfx_pkg::ONE_Q30;
		else
			sum_clamp = sum_sd[T][30:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_sd[T] >= 8'd31)
				e <= '0;
			else
				e <= sum_clamp >> n_sd[T][4:0];
		end
	end

endmodule

// ===== sv/erf_exp_approximation_unit.sv =====
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   x_value   (Q3.12, signed 16)
// result    out        out_valid / out_ready erf_value (Q1.14, signed 16)
//
// One request per cycle while in_ready is high; each passes the two 28-stage exp
// evaluators (12 Taylor terms, two stages each) and the 18-stage bit-per-
// stage divider. The whole pipeline advances when the output is free or taken;
// in_ready drops only while a finished result is held. arst_n clears the
// valid bits only.
module erf_exp_approximation_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] x_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] erf_value
);

	localparam int unsigned EL  = erfx_pkg::EXP_LAT;
	localparam int unsigned DB  = erfx_pkg::DIV_BITS;
	localparam int unsigned N1  = 2 + EL;
	localparam int unsigned DV0 = N1 + 1;
	localparam int unsigned LAT = DV0 + DB + 2;

	logic               en;
	logic [LAT-1:0]     vld_s;
	logic [LAT-1:0]     neg_s;
	logic [LAT-1:0]     zero_s;
	logic [16:0]        a_s [0:N1-1];

	logic [48:0]        p1;
	logic [33:0]        aa;
	logic [36:0]        t1_s2;
	logic [36:0]        t2_s2;
	logic [30:0]        e1;
	logic [30:0]        e2;

	logic [61:0]        nump;
	logic [48:0]        denp;
	logic [30:0]        num_s;
	logic [46:0]        den_s;

	logic [63:0]        rem_sd [0:DB];
	logic [46:0]        den_sd [0:DB];
	logic [16:0]        q_sd   [0:DB];
	logic               ovf_sd [0:DB];

	logic               sat;
	logic [16:0]        r;
	logic [14:0]        mag;
	logic [15:0]        res;
	logic [15:0]        raw;

	assign en        = !vld_s[LAT-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[LAT-1];
	assign raw       = x_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s  <= {neg_s[LAT-2:0], raw[15]};
			zero_s <= {zero_s[LAT-2:0], raw == 16'd0};
			a_s[0] <= raw[15] ? 17'(17'h10000 - 17'(raw)) : 17'(raw);
			for (int i = 1; i < N1; i++)
				a_s[i] <= a_s[i-1];
		end
	end

	assign p1 = 49'(a_s[0]) * 49'(erfx_pkg::A_MAG_Q30);
	assign aa = 34'(a_s[0]) * 34'(a_s[0]);

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s2 <= p1[48:12];
			t2_s2 <= {aa[30:0], 6'b0};
		end
	end

	erfx_exp u_exp1 (.clk(clk), .en(en), .t(t1_s2), .e(e1));
	erfx_exp u_exp2 (.clk(clk), .en(en), .t(t2_s2), .e(e2));

	assign nump = 62'(erfx_pkg::ONE_Q30 - e1) * 62'(e2);
	assign denp = 49'(a_s[N1-1]) * 49'(erfx_pkg::B_Q30);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s <= nump[60:30];
			den_s <= denp[46:0];
		end
	end

	// quotient (num << 28) / den, 17 bits, overflow flagged up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= {5'b0, num_s, 28'b0};
			den_sd[0] <= den_s;
			q_sd[0]   <= '0;
			ovf_sd[0] <= {5'b0, num_s, 28'b0} >= (64'(den_s) << DB);
		end
	end

	for (genvar j = 1; j <= DB; j++) begin : g_div
		logic [63:0] dsh;

		assign dsh = 64'(den_sd[j-1]) << (DB - j);

		always_ff @(posedge clk) begin
			if (en) begin
				den_sd[j] <= den_sd[j-1];
				ovf_sd[j] <= ovf_sd[j-1];
				if (rem_sd[j-1] >= dsh) begin
					rem_sd[j] <= rem_sd[j-1] - dsh;
					q_sd[j]   <= q_sd[j-1] | (17'd1 << (DB - j));
				end else begin
					rem_sd[j] <= rem_sd[j-1];
					q_sd[j]   <= q_sd[j-1];
				end
			end
		end
	end

	always_comb begin
		sat = ovf_sd[DB] || (q_sd[DB] > 17'd65536);
		r   = sat ? 17'd0 : 17'(17'd65536 - q_sd[DB]);
		mag = 15'((18'(r) + 18'd2) >> 2);
		if (zero_s[LAT-2])
			res = '0;
		else if (neg_s[LAT-2])
			res = 16'(17'd0 - 17'(mag));
		else
			res = 16'(mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			erf_value <= res;
		end
	end

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (erf_value <= 16'sd16384) && (erf_value >= -16'sd16384))
		else $error("erf_value out of range");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_s[LAT-1] |-> erf_value == 16'sd0)
		else $error("zero argument gave nonzero result");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (erf_value != 16'sd0) |-> erf_value[15] == neg_s[LAT-1])
		else $error("result sign differs from argument sign");

endmodule

// ===== tb/erf_exp_approximation_unit_test.sv =====
`timescale 1ns / 1ps

module erf_exp_approximation_unit_test;

	localparam int LATENCY     = 50;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 1000;

	// e^(-t), t and result in Q.30
	function automatic longint unsigned exp_neg_fixed(input longint unsigned t);
		longint unsigned n, g, term;
		longint sum;
		n = t / 64'd744261118;
		g = t - n * 64'd744261118;
		sum = 64'sd1073741824;
		term = 64'd1073741824;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * g) >> 30) / k;
			if (k % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > 64'sd1073741824)
			sum = 64'sd1073741824;
		if (n >= 31)
			return 0;
		return longint'(sum) >> n;
	endfunction

	function automatic logic signed [15:0] erf_fixed(input logic signed [15:0] x);
		longint unsigned a, e1, e2, num, den, q, mag;
		longint r;
		a = x[15] ? (64'h10000 - {48'd0, x}) : {48'd0, x};
		if (a == 0)
			return 16'sd0;
		e1 = exp_neg_fixed((a * 64'd2126008812) >> 12);
		e2 = exp_neg_fixed((a * a) << 6);
		num = ((64'd1073741824 - e1) * e2) >> 30;
		den = 64'd2160084138 * a;
		q = (num << 28) / den;
		r = 65536 - longint'(q > 65536 ? 65536 : q);
		if (r < 0)
			r = 0;
		mag = (longint'(r) + 2) >> 2;
		if (mag > 16384)
			mag = 16384;
		return x[15] ? -16'(mag) : 16'(mag);
	endfunction

	class erf_scoreboard;
		logic signed [15:0] erf_pending[$];
		int mismatches;

		function void note_request(logic signed [15:0] x);
			erf_pending.push_back(erf_fixed(x));
		endfunction

		function void check_result(logic signed [15:0] got);
			logic signed [15:0] want;
			if (erf_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d", got);
				return;
			end
			want = erf_pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("erf mismatch: expected %0d got %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] x_value = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] erf_value;

	erf_scoreboard board = new();
	bit long_hold = 0;
	int cycles = 0;

	erf_exp_approximation_unit i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (out_valid && out_ready)
			board.check_result(erf_value);
		if (in_valid && in_ready)
			board.note_request(x_value);
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (long_hold)
				out_ready <= 0;
			else if (phase % 300 < 80)
				out_ready <= 1;
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_x(input logic signed [15:0] x);
		in_valid <= 1;
		x_value <= x;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic idle_sender(input int n);
		in_valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic signed [15:0] random_x();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 12288)) - 6144);
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			default: return 16'($signed($urandom_range(0, 64)) - 32);
		endcase
	endfunction

	initial begin
		logic signed [15:0] directed[$];
		int sent;
		directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, -16'sd32767,
			16'sd4096, -16'sd4096, 16'sd2048, -16'sd2048, 16'sd12288, -16'sd12288,
			16'sd16384, 16'sd2, 16'sd16, 16'h5555, 16'hAAAA, 16'sd8192, -16'sd8192,
			16'sd409, -16'sd409};
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (directed[i])
			send_x(directed[i]);
		idle_sender(1);
		while (board.erf_pending.size() != 0)
			@(negedge clk);
		@(negedge clk);

		long_hold = 1;
		fork
			begin
				repeat (200) @(negedge clk);
				long_hold = 0;
			end
			for (int i = 0; i < 120; i++)
				send_x(random_x());
		join
		idle_sender(1);

		sent = 0;
		while (sent < N_RANDOM) begin
			int burst;
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst; i++) begin
				send_x(random_x());
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				idle_sender($urandom_range(1, 12));
		end
		idle_sender(1);
		while (board.erf_pending.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 20) @(negedge clk);
		if (board.mismatches == 0 && board.erf_pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
sv/erfx_pkg.sv
sv/erfx_exp.sv
sv/erf_exp_approximation_unit.sv
tb/erf_exp_approximation_unit_test.sv
